/* hdl/ilr_pkg.sv */
// Shared types and constants of the interrupt line remapper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ilr_pkg;

    localparam int NUM_LINES   = 64;
    localparam int MAX_VIRTUAL = 27;

    localparam int LINE_W  = 6;
    localparam int VNUM_W  = 5;
    localparam int WORD_W  = 32;
    localparam int PEND_W  = 28;   // pending field keeps bits 0..27
    localparam int ENABLE_W = 28;  // enable mask bits that count

    localparam int NUM_SWEEP = 2 * WORD_W;            // status bits walked per collect
    localparam int SWEEP_W   = $clog2(NUM_SWEEP + 1);
    localparam int LINE_AW   = $clog2(NUM_LINES);
    localparam int SLOT_CNT  = MAX_VIRTUAL + 1;
    localparam int SLOT_AW   = $clog2(SLOT_CNT);

    typedef enum logic [1:0] {
        KIND_ASSIGN  = 2'd0,
        KIND_COLLECT = 2'd1,
        KIND_ENABLE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ASSIGN,
        ST_COLLECT,
        ST_ENABLE,
        ST_DONE
    } state_t;

    // write request into the line-to-number table
    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        logic [VNUM_W-1:0]  num;
    } lmap_wr_t;

    // registered read of the line-to-number table
    typedef struct packed {
        logic              valid;
        logic [VNUM_W-1:0] num;
    } lmap_rd_t;

    // write request into the number-to-line table
    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        logic [LINE_W-1:0]  line;
    } nmap_wr_t;

endpackage

/* hdl/ilr_line_map.sv */
// Line-to-number table: memory with registered read and per-entry valid bits.
// Depends on ilr_pkg.
`timescale 1ns / 1ps

module ilr_line_map
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ilr_pkg::LINE_AW-1:0] rd_addr,
    input  ilr_pkg::lmap_wr_t           wr,
    output ilr_pkg::lmap_rd_t           rd
);

    logic [ilr_pkg::VNUM_W-1:0] mem [ilr_pkg::NUM_LINES];
    logic [ilr_pkg::NUM_LINES-1:0] valid_reg;
    logic [ilr_pkg::VNUM_W-1:0] rd_num_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.num;
        end
        rd_num_reg <= mem[rd_addr];
    end

    // entries never written read as unassigned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.num   = rd_valid_reg ? rd_num_reg : '0;

endmodule

/* hdl/ilr_number_map.sv */
// Number-to-line table: small register file, cleared at reset, one write and
// one read port. Depends on ilr_pkg.
`timescale 1ns / 1ps

module ilr_number_map
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ilr_pkg::nmap_wr_t           wr,
    input  logic [ilr_pkg::SLOT_AW-1:0] rd_addr,
    output logic [ilr_pkg::LINE_W-1:0]  rd_line
);

    logic [ilr_pkg::LINE_W-1:0] slot_reg [ilr_pkg::SLOT_CNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ilr_pkg::SLOT_CNT; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            slot_reg[wr.addr] <= wr.line;
        end
    end

    assign rd_line = slot_reg[rd_addr];

endmodule

/* hdl/interrupt_line_remapper.sv */
// Interrupt line remapper top level: control sequencer, serial status and
// enable shift registers, result register. Depends on ilr_pkg, ilr_line_map,
// ilr_number_map.
//
// Usage: a request (req_valid/req_ready) carries kind, line, status words and
// an enable mask; each request gives one result on rsp_valid/rsp_ready.
// Assign (kind 0) returns the line's virtual number, allocating the next one
// on first use, or overflow when all numbers are in use. Collect (kind 1)
// walks the 64 status bits one per cycle through the line table and returns
// clear words and the virtual pending mask. Enable (kind 2) walks the 28 mask
// bits one per cycle through the number table and returns enable words.
// Kind 3 returns all zeros. One request is in work at a time; req_ready
// returns with the result load, so back-to-back collects are set by the
// one-bit-per-cycle walk over the line table's single read port.
// The result register lets a new request be taken while a result waits; a
// finished request holds in the sequencer until the receiver frees it.
// Reset clears both tables, the used count and second_bank.
// cfg_wr_en/cfg_wr_data write second_bank; write it only while idle.
`timescale 1ns / 1ps

module interrupt_line_remapper
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         kind,
    input  logic [ilr_pkg::LINE_W-1:0]         line,
    input  logic [ilr_pkg::WORD_W-1:0]         status_low,
    input  logic [ilr_pkg::WORD_W-1:0]         status_high,
    input  logic [ilr_pkg::WORD_W-1:0]         enable_mask,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [ilr_pkg::VNUM_W-1:0]         virtual_number,
    output logic                               overflow,
    output logic [ilr_pkg::PEND_W-1:0]         pending_mask,
    output logic [ilr_pkg::WORD_W-1:0]         clear_low,
    output logic [ilr_pkg::WORD_W-1:0]         clear_high,
    output logic [ilr_pkg::WORD_W-1:0]         enable_low,
    output logic [ilr_pkg::WORD_W-1:0]         enable_high,
    output logic                               write_high
);

    ilr_pkg::state_t state_reg, state_next;
    logic [ilr_pkg::SWEEP_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [ilr_pkg::LINE_W-1:0]    line_reg, line_next;
    logic                          line_ok_reg, line_ok_next;
    logic [ilr_pkg::NUM_SWEEP-1:0] status_sr_reg, status_sr_next;
    logic [ilr_pkg::ENABLE_W-1:0]  emask_sr_reg, emask_sr_next;
    logic                          probe_reg, probe_next;
    logic [ilr_pkg::PEND_W-1:0]    pend_acc_reg, pend_acc_next;
    logic [ilr_pkg::NUM_SWEEP-1:0] en_acc_reg, en_acc_next;
    logic [ilr_pkg::VNUM_W-1:0]    vnum_res_reg, vnum_res_next;
    logic                          ovf_res_reg, ovf_res_next;
    logic [ilr_pkg::VNUM_W-1:0]    used_reg, used_next;
    logic                          bank_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [ilr_pkg::VNUM_W-1:0]    out_vnum_reg, out_vnum_next;
    logic                          out_ovf_reg, out_ovf_next;
    logic [ilr_pkg::PEND_W-1:0]    out_pend_reg, out_pend_next;
    logic [ilr_pkg::WORD_W-1:0]    out_clr_lo_reg, out_clr_lo_next;
    logic [ilr_pkg::WORD_W-1:0]    out_clr_hi_reg, out_clr_hi_next;
    logic [ilr_pkg::WORD_W-1:0]    out_en_lo_reg, out_en_lo_next;
    logic [ilr_pkg::WORD_W-1:0]    out_en_hi_reg, out_en_hi_next;
    logic                          out_wh_reg, out_wh_next;

    logic [ilr_pkg::LINE_AW-1:0]   lmap_rd_addr;
    ilr_pkg::lmap_wr_t             lmap_wr;
    ilr_pkg::lmap_rd_t             lmap_rd;
    ilr_pkg::nmap_wr_t             nmap_wr;
    logic [ilr_pkg::LINE_W-1:0]    nmap_line;
    logic [ilr_pkg::LINE_W-1:0]    slot_line;
    logic [ilr_pkg::VNUM_W-1:0]    new_num;

    ilr_line_map u_line_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (lmap_rd_addr),
        .wr      (lmap_wr),
        .rd      (lmap_rd)
    );

    ilr_number_map u_number_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (nmap_wr),
        .rd_addr (cnt_reg[ilr_pkg::SLOT_AW-1:0]),
        .rd_line (nmap_line)
    );

    // numbers above the table read as line 0
    assign slot_line = (cnt_reg <= ilr_pkg::SWEEP_W'(ilr_pkg::MAX_VIRTUAL)) ? nmap_line : '0;
    assign new_num   = used_reg + ilr_pkg::VNUM_W'(1);
    assign lmap_rd_addr = (state_reg == ilr_pkg::ST_IDLE) ? line[ilr_pkg::LINE_AW-1:0]
                                                          : cnt_reg[ilr_pkg::LINE_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            probe_reg     <= 1'b0;
            used_reg      <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            probe_reg     <= probe_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bank_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        line_reg       <= line_next;
        line_ok_reg    <= line_ok_next;
        status_sr_reg  <= status_sr_next;
        emask_sr_reg   <= emask_sr_next;
        pend_acc_reg   <= pend_acc_next;
        en_acc_reg     <= en_acc_next;
        vnum_res_reg   <= vnum_res_next;
        ovf_res_reg    <= ovf_res_next;
        out_vnum_reg   <= out_vnum_next;
        out_ovf_reg    <= out_ovf_next;
        out_pend_reg   <= out_pend_next;
        out_clr_lo_reg <= out_clr_lo_next;
        out_clr_hi_reg <= out_clr_hi_next;
        out_en_lo_reg  <= out_en_lo_next;
        out_en_hi_reg  <= out_en_hi_next;
        out_wh_reg     <= out_wh_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        line_next       = line_reg;
        line_ok_next    = line_ok_reg;
        status_sr_next  = status_sr_reg;
        emask_sr_next   = emask_sr_reg;
        probe_next      = probe_reg;
        pend_acc_next   = pend_acc_reg;
        en_acc_next     = en_acc_reg;
        vnum_res_next   = vnum_res_reg;
        ovf_res_next    = ovf_res_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_vnum_next   = out_vnum_reg;
        out_ovf_next    = out_ovf_reg;
        out_pend_next   = out_pend_reg;
        out_clr_lo_next = out_clr_lo_reg;
        out_clr_hi_next = out_clr_hi_reg;
        out_en_lo_next  = out_en_lo_reg;
        out_en_hi_next  = out_en_hi_reg;
        out_wh_next     = out_wh_reg;
        lmap_wr         = '0;
        nmap_wr         = '0;
        req_ready       = 1'b0;

        unique case (state_reg)
            ilr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    kind_next      = kind;
                    line_next      = line;
                    line_ok_next   = {1'b0, line} < (ilr_pkg::LINE_W + 1)'(ilr_pkg::NUM_LINES);
                    status_sr_next = {bank_reg ? status_high : '0, status_low};
                    emask_sr_next  = enable_mask[ilr_pkg::ENABLE_W-1:0];
                    cnt_next       = '0;
                    probe_next     = 1'b0;
                    pend_acc_next  = '0;
                    en_acc_next    = '0;
                    vnum_res_next  = '0;
                    ovf_res_next   = 1'b0;
                    unique case (kind)
                        ilr_pkg::KIND_ASSIGN:  state_next = ilr_pkg::ST_ASSIGN;
                        ilr_pkg::KIND_COLLECT: state_next = ilr_pkg::ST_COLLECT;
                        ilr_pkg::KIND_ENABLE:  state_next = ilr_pkg::ST_ENABLE;
                        default:               state_next = ilr_pkg::ST_DONE;
                    endcase
                end
            end

            ilr_pkg::ST_ASSIGN:
            begin
                // table read was issued at acceptance
                priority if (!line_ok_reg)
                begin
                    vnum_res_next = '0;
                end
                else if (lmap_rd.num != '0)
                begin
                    vnum_res_next = lmap_rd.num;
                end
                else if (used_reg >= ilr_pkg::VNUM_W'(ilr_pkg::MAX_VIRTUAL))
                begin
                    ovf_res_next = 1'b1;
                end
                else
                begin
                    vnum_res_next = new_num;
                    used_next     = new_num;
                    lmap_wr.en    = 1'b1;
                    lmap_wr.addr  = line_reg[ilr_pkg::LINE_AW-1:0];
                    lmap_wr.num   = new_num;
                    nmap_wr.en    = 1'b1;
                    nmap_wr.addr  = new_num[ilr_pkg::SLOT_AW-1:0];
                    nmap_wr.line  = line_reg;
                end
                state_next = ilr_pkg::ST_DONE;
            end

            ilr_pkg::ST_COLLECT:
            begin
                // status word rotates once around; read data arrives in the cycle after its address
                if (cnt_reg < ilr_pkg::SWEEP_W'(ilr_pkg::NUM_SWEEP))
                begin
                    status_sr_next = {status_sr_reg[0],
                                      status_sr_reg[ilr_pkg::NUM_SWEEP-1:1]};
                    probe_next = status_sr_reg[0] &&
                                 (cnt_reg < ilr_pkg::SWEEP_W'(ilr_pkg::NUM_LINES));
                end
                else
                begin
                    probe_next = 1'b0;
                    state_next = ilr_pkg::ST_DONE;
                end
                if (probe_reg)
                begin
                    pend_acc_next = pend_acc_reg |
                                    ilr_pkg::PEND_W'(32'd1 << lmap_rd.num);
                end
                cnt_next = cnt_reg + ilr_pkg::SWEEP_W'(1);
            end

            ilr_pkg::ST_ENABLE:
            begin
                if (emask_sr_reg[0])
                begin
                    en_acc_next = en_acc_reg | (ilr_pkg::NUM_SWEEP'(1) << slot_line);
                end
                emask_sr_next = {1'b0, emask_sr_reg[ilr_pkg::ENABLE_W-1:1]};
                cnt_next      = cnt_reg + ilr_pkg::SWEEP_W'(1);
                if (cnt_reg == ilr_pkg::SWEEP_W'(ilr_pkg::ENABLE_W - 1))
                begin
                    state_next = ilr_pkg::ST_DONE;
                end
            end

            ilr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_vnum_next   = '0;
                    out_ovf_next    = 1'b0;
                    out_pend_next   = '0;
                    out_clr_lo_next = '0;
                    out_clr_hi_next = '0;
                    out_en_lo_next  = '0;
                    out_en_hi_next  = '0;
                    out_wh_next     = 1'b0;
                    unique case (kind_reg)
                        ilr_pkg::KIND_ASSIGN:
                        begin
                            out_vnum_next = vnum_res_reg;
                            out_ovf_next  = ovf_res_reg;
                        end
                        ilr_pkg::KIND_COLLECT:
                        begin
                            // virtual bit 0 collects unassigned lines
                            out_pend_next   = pend_acc_reg & ~ilr_pkg::PEND_W'(1);
                            out_clr_lo_next = status_sr_reg[ilr_pkg::WORD_W-1:0];
                            out_clr_hi_next = status_sr_reg[ilr_pkg::NUM_SWEEP-1:ilr_pkg::WORD_W];
                            out_wh_next     = bank_reg;
                        end
                        ilr_pkg::KIND_ENABLE:
                        begin
                            out_en_lo_next = en_acc_reg[ilr_pkg::WORD_W-1:0];
                            out_en_hi_next = en_acc_reg[ilr_pkg::NUM_SWEEP-1:ilr_pkg::WORD_W];
                            out_wh_next    = bank_reg;
                        end
                        default:
                        begin
                            out_wh_next = 1'b0;
                        end
                    endcase
                    state_next = ilr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ilr_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid      = out_valid_reg;
    assign virtual_number = out_vnum_reg;
    assign overflow       = out_ovf_reg;
    assign pending_mask   = out_pend_reg;
    assign clear_low      = out_clr_lo_reg;
    assign clear_high     = out_clr_hi_reg;
    assign enable_low     = out_en_lo_reg;
    assign enable_high    = out_en_hi_reg;
    assign write_high     = out_wh_reg;

endmodule

/* hdl/ilr_checker.sv */
// Port-level checks of the interrupt line remapper, bound to the top level.
// Depends on ilr_pkg and interrupt_line_remapper.
`timescale 1ns / 1ps

module ilr_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [ilr_pkg::VNUM_W-1:0] virtual_number,
    input logic                       overflow,
    input logic [ilr_pkg::PEND_W-1:0] pending_mask,
    input logic [ilr_pkg::WORD_W-1:0] clear_high,
    input logic [ilr_pkg::WORD_W-1:0] enable_low,
    input logic [ilr_pkg::WORD_W-1:0] enable_high,
    input logic                       write_high
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(virtual_number) &&
        $stable(overflow) && $stable(pending_mask) && $stable(enable_low))
        else $error("result changed while stalled");

    a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow |-> virtual_number == '0 && pending_mask == '0 &&
        enable_low == '0 && enable_high == '0 && !write_high)
        else $error("overflow result carries other fields");

    a_pend_bit0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !pending_mask[0])
        else $error("virtual bit 0 reported pending");

    a_no_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !write_high |-> clear_high == '0)
        else $error("upper clear word without second bank");

endmodule

bind interrupt_line_remapper ilr_checker u_ilr_checker (.*);
